// ===== hdl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and constants of the glyph column segmenter: field widths,
// register indexes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gcs_pkg;

    // Pixel value that counts as an empty position.
    localparam logic [23:0] WHITE_PIXEL = 24'hFFFFFF;

    // Field widths of the streams and of the configuration port.
    localparam int PIXEL_W      = 24;
    localparam int GLYPH_COL_W  = 7;
    localparam int GLYPH_TOP_W  = 6;
    localparam int OUT_TDATA_W  = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int WIDTH_REG_W  = 8;
    localparam int HEIGHT_REG_W = 7;
    localparam int MINW_REG_W   = 7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take in one pixel beat
        logic scan_init;  // frame end seen, prepare the column scan
        logic eval_step;  // evaluate the current column and advance
        logic flush;      // deliver the final result, clear the frame
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close_run;  // current column closes an open run
        logic last_col;   // current column is the last one of the frame
        logic out_free;   // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/gcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcs_ctrl
// Controller of the segmenter: collects pixels, then steps the column scan
// (read, evaluate) and finally flushes the last result of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    output logic                  s_tready,
    input  gcs_pkg::status_t      status,
    output gcs_pkg::cmd_t         cmd
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_READ    = 2'd1;
    localparam logic [1:0] ST_EVAL    = 2'd2;
    localparam logic [1:0] ST_FLUSH   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready      = (state_reg == ST_COLLECT);
    assign cmd.capture   = s_tvalid && s_tready;
    assign cmd.scan_init = cmd.capture && s_tlast;
    assign cmd.eval_step = (state_reg == ST_EVAL) && (!status.close_run || status.out_free);
    assign cmd.flush     = (state_reg == ST_FLUSH) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (cmd.scan_init)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (cmd.eval_step)
                begin
                    state_next = status.last_col ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                if (cmd.flush)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The beat that ends a frame hands over to the scan; no pixel follows it directly.
    a_no_pixel_after_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_init |=> !s_tready)
        else $error("pixel accepted right after frame end");

    // A scan always runs through at least one read before any evaluation.
    a_read_before_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_init |=> (state_reg == ST_READ))
        else $error("scan did not start with a column read");

    // A flush hands the block back to pixel collection.
    a_flush_to_collect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> s_tready)
        else $error("pixel input not reopened after flush");

endmodule

`default_nettype wire

// ===== hdl/gcs_datapath.sv =====
// ----------------------------------------------------------------------------
// gcs_datapath
// Datapath of the segmenter: pixel position counters, per-column marks and
// top-row memory, run tracking of the column scan and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_datapath #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  gcs_pkg::cmd_t                              cmd,
    output gcs_pkg::status_t                           status,
    input  wire logic [gcs_pkg::PIXEL_W-1:0]           pixel,
    input  wire logic [gcs_pkg::WIDTH_REG_W-1:0]       eff_width,
    input  wire logic [gcs_pkg::HEIGHT_REG_W-1:0]      eff_height,
    input  wire logic [gcs_pkg::MINW_REG_W-1:0]        min_width,
    input  wire logic                                  m_tready,
    output logic                                       out_valid,
    output logic [gcs_pkg::GLYPH_COL_W-1:0]            out_left,
    output logic [gcs_pkg::GLYPH_COL_W-1:0]            out_right,
    output logic [gcs_pkg::GLYPH_TOP_W-1:0]            out_top,
    output logic                                       out_none,
    output logic                                       out_last
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int OUT_CW = gcs_pkg::GLYPH_COL_W;
    localparam int OUT_TW = gcs_pkg::GLYPH_TOP_W;

    // Pixel position.
    logic [CW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;
    logic [CW:0]          col_inc;
    logic [RW:0]          row_inc;

    // Column store.
    logic [MAX_WIDTH-1:0] marks_reg;
    logic [RW-1:0]        top_mem [MAX_WIDTH];
    logic [RW-1:0]        rd_data_reg;
    logic                 mark_new;

    // Scan state.
    logic [CW-1:0]        x_reg;
    logic                 open_reg;
    logic [CW-1:0]        left_reg;
    logic [RW-1:0]        run_top_reg;
    logic [CW-1:0]        run_dist;
    logic                 cur_marked;

    // Result waiting for its successor, so that the final one can carry last.
    logic                 pend_valid_reg;
    logic [CW-1:0]        pend_left_reg;
    logic [CW-1:0]        pend_right_reg;
    logic [RW-1:0]        pend_top_reg;

    logic                 out_valid_reg;
    logic                 load_out;

    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign mark_new   = cmd.capture && (pixel != gcs_pkg::WHITE_PIXEL) && !marks_reg[col_reg];
    assign cur_marked = marks_reg[x_reg];
    assign run_dist   = x_reg - left_reg;

    assign status.close_run = !cur_marked && open_reg && (int'(run_dist) >= int'(min_width));
    assign status.last_col  = (int'(x_reg) + 1) >= int'(eff_width);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign load_out  = (cmd.eval_step && status.close_run && pend_valid_reg) || cmd.flush;
    assign out_valid = out_valid_reg;

    // Top-row memory: one write port for capture, one registered read for the scan.
    always_ff @(posedge clk)
    begin
        if (mark_new)
        begin
            top_mem[col_reg] <= row_reg;
        end
        rd_data_reg <= top_mem[x_reg];
    end

    // Position counters and column marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            marks_reg <= '0;
        end
        else if (cmd.flush)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            marks_reg <= '0;
        end
        else if (cmd.capture)
        begin
            if (mark_new)
            begin
                marks_reg[col_reg] <= 1'b1;
            end
            if (int'(col_inc) >= int'(eff_width))
            begin
                col_reg <= '0;
                if (int'(row_inc) >= int'(eff_height))
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_inc[RW-1:0];
                end
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Column scan and pending result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg          <= '0;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            x_reg          <= '0;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.eval_step)
        begin
            x_reg <= x_reg + 1'b1;
            if (cur_marked)
            begin
                if (!open_reg)
                begin
                    open_reg <= 1'b1;
                end
            end
            else if (status.close_run)
            begin
                open_reg       <= 1'b0;
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Run payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.eval_step)
        begin
            if (cur_marked)
            begin
                if (!open_reg)
                begin
                    left_reg    <= x_reg;
                    run_top_reg <= rd_data_reg;
                end
                else if (rd_data_reg < run_top_reg)
                begin
                    run_top_reg <= rd_data_reg;
                end
            end
            else if (status.close_run)
            begin
                pend_left_reg  <= left_reg;
                pend_right_reg <= x_reg;
                pend_top_reg   <= run_top_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (cmd.flush && !pend_valid_reg)
            begin
                out_left  <= '0;
                out_right <= '0;
                out_top   <= '0;
                out_none  <= 1'b1;
            end
            else
            begin
                out_left  <= OUT_CW'(pend_left_reg);
                out_right <= OUT_CW'(pend_right_reg);
                out_top   <= OUT_TW'(pend_top_reg);
                out_none  <= 1'b0;
            end
            out_last <= cmd.flush;
        end
    end

    // A result is only loaded when the output register is free or draining.
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an undelivered beat");

    // After a flush every column mark is clear and the final beat is on offer.
    a_flush_clears_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (marks_reg == '0) && out_valid_reg && out_last)
        else $error("frame not closed properly by flush");

    // A frame start sees no leftover pending result.
    a_scan_init_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_init |=> !pend_valid_reg && !open_reg && (x_reg == '0))
        else $error("scan started with stale run state");

endmodule

`default_nettype wire

// ===== hdl/glyph_column_segmenter_core.sv =====
// ----------------------------------------------------------------------------
// glyph_column_segmenter_core
// Vertical-projection glyph segmentation of a background-cleared image.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the slave stream in row-major order, one beat per pixel,
// with s_tlast high on the final pixel of the frame. During a frame one beat
// is taken every cycle. A pure white pixel counts as empty; any other value
// marks its column and, for the first such pixel, records the row.
// The beat with s_tlast starts the column scan. The scan steps through each
// column (registered read of the top-row memory, then evaluation) and ends
// with a flush; s_tready stays low until that flush, which comes later if the
// receiver stalls. Each closed run leaves as one master beat; the last beat of
// the frame has m_tlast high. A frame without a closed run gives one beat with
// m_tuser (none found) high and zero coordinates.
// Results pass through a single output register: a stalled m_tready holds the
// beat and pauses the scan, but never loses or repeats a result.
// Reset (rst_n low, asynchronous) clears all column marks and counters and
// loads image_width 128, image_height 64, min_width 7. Configuration writes
// are meant for idle periods between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_column_segmenter_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Slave stream. tdata: pixel[23:0]. tlast: frame_end.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [gcs_pkg::PIXEL_W-1:0]           s_tdata,
    input  wire logic                                  s_tlast,
    // Master stream. tdata: glyph_left[6:0], glyph_right[13:7],
    // glyph_top[19:14], zero[23:20]. tuser: none_found. tlast: last.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [gcs_pkg::OUT_TDATA_W-1:0]            m_tdata,
    output logic                                       m_tuser,
    output logic                                       m_tlast,
    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire logic [gcs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [gcs_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PAD_W = gcs_pkg::OUT_TDATA_W - 2 * gcs_pkg::GLYPH_COL_W
                           - gcs_pkg::GLYPH_TOP_W;

    logic [gcs_pkg::WIDTH_REG_W-1:0]  width_cfg_reg;
    logic [gcs_pkg::HEIGHT_REG_W-1:0] height_cfg_reg;
    logic [gcs_pkg::MINW_REG_W-1:0]   minw_cfg_reg;

    logic [gcs_pkg::WIDTH_REG_W-1:0]  eff_width;
    logic [gcs_pkg::HEIGHT_REG_W-1:0] eff_height;

    gcs_pkg::cmd_t                    cmd;
    gcs_pkg::status_t                 status;

    logic [gcs_pkg::GLYPH_COL_W-1:0]  out_left;
    logic [gcs_pkg::GLYPH_COL_W-1:0]  out_right;
    logic [gcs_pkg::GLYPH_TOP_W-1:0]  out_top;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 8'd128;
            height_cfg_reg <= 7'd64;
            minw_cfg_reg   <= 7'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcs_pkg::REG_IMAGE_WIDTH:
                begin
                    width_cfg_reg <= cfg_data;
                end
                gcs_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_cfg_reg <= cfg_data[gcs_pkg::HEIGHT_REG_W-1:0];
                end
                gcs_pkg::REG_MIN_WIDTH:
                begin
                    minw_cfg_reg <= cfg_data[gcs_pkg::MINW_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Zero acts as one, and values above the built-in size are clamped to it.
    always_comb
    begin
        priority if (width_cfg_reg == '0)
        begin
            eff_width = gcs_pkg::WIDTH_REG_W'(1);
        end
        else if (int'(width_cfg_reg) > MAX_WIDTH)
        begin
            eff_width = gcs_pkg::WIDTH_REG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_cfg_reg;
        end

        priority if (height_cfg_reg == '0)
        begin
            eff_height = gcs_pkg::HEIGHT_REG_W'(1);
        end
        else if (int'(height_cfg_reg) > MAX_HEIGHT)
        begin
            eff_height = gcs_pkg::HEIGHT_REG_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = height_cfg_reg;
        end
    end

    gcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gcs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pixel      (s_tdata),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .min_width  (minw_cfg_reg),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_top    (out_top),
        .out_none   (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_top, out_right, out_left};

endmodule

`default_nettype wire
